[rtl/core/rmq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;
  localparam int FracBits = 16;
  localparam int FieldW = 18;
  localparam int ArgW = 21;
  localparam int RadW = ArgW + FracBits;
  localparam int SqW = 19;
  localparam int NumW = 20;
  localparam int DivW = NumW + FracBits;
  localparam int QW = 21;
  localparam int QueueDepth = 4;
  localparam int QueueAw = 2;

  typedef logic signed [FieldW-1:0] field_t;

  typedef enum logic [1:0] {
    PIV_X = 2'd0,
    PIV_Y = 2'd1,
    PIV_Z = 2'd2,
    PIV_W = 2'd3
  } pivot_t;

  typedef struct packed {
    logic                   degen;
    pivot_t                 pivot;
    logic [ArgW-1:0]        arg;
    logic signed [NumW-1:0] n0;
    logic signed [NumW-1:0] n1;
    logic signed [NumW-1:0] n2;
  } job_t;

  function automatic field_t sat18(input logic signed [QW-1:0] v);
    logic signed [QW-1:0] hi;
    logic signed [QW-1:0] lo;
    begin
      hi = QW'(131071);
      lo = -QW'(131072);
      if (v > hi) sat18 = field_t'(131071);
      else if (v < lo) sat18 = field_t'(-131072);
      else sat18 = v[FieldW-1:0];
    end
  endfunction
endpackage
`default_nettype wire

[rtl/core/rmq_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module rmq_front import rmq_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   take,
  input  wire field_t m00, input wire field_t m01, input wire field_t m02,
  input  wire field_t m10, input wire field_t m11, input wire field_t m12,
  input  wire field_t m20, input wire field_t m21, input wire field_t m22,
  output logic        job_valid,
  output job_t        job
);
  // Classifies the matrix: trace branch or pivot, and forms the sqrt argument
  // plus the three numerators in the order (a, b, c) for the other components.
  localparam logic signed [ArgW-1:0] One = ArgW'(1) <<< FracBits;
  logic signed [ArgW-1:0] d0, d1, d2, tr, a;
  job_t j;

  always_comb begin
    d0 = ArgW'(m00); d1 = ArgW'(m11); d2 = ArgW'(m22);
    tr = d0 + d1 + d2;
    j = '0;
    if (tr > 0) begin
      j.pivot = PIV_W;
      a = tr + One;
      j.n0 = NumW'(m21) - NumW'(m12);
      j.n1 = NumW'(m02) - NumW'(m20);
      j.n2 = NumW'(m10) - NumW'(m01);
    end else if (m00 < m11 ? (m11 < m22) : (m00 < m22)) begin
      j.pivot = PIV_Z;
      a = d2 - d0 - d1 + One;
      j.n0 = NumW'(m10) - NumW'(m01);
      j.n1 = NumW'(m02) + NumW'(m20);
      j.n2 = NumW'(m12) + NumW'(m21);
    end else if (m00 < m11) begin
      j.pivot = PIV_Y;
      a = d1 - d2 - d0 + One;
      j.n0 = NumW'(m02) - NumW'(m20);
      j.n1 = NumW'(m21) + NumW'(m12);
      j.n2 = NumW'(m01) + NumW'(m10);
    end else begin
      j.pivot = PIV_X;
      a = d0 - d1 - d2 + One;
      j.n0 = NumW'(m21) - NumW'(m12);
      j.n1 = NumW'(m10) + NumW'(m01);
      j.n2 = NumW'(m20) + NumW'(m02);
    end
    j.degen = (a <= 0);
    j.arg = j.degen ? ArgW'(1) : a;
  end

  always_ff @(posedge clk) begin
    if (rst) job_valid <= 1'b0;
    else job_valid <= take;
    job <= j;
  end
endmodule
`default_nettype wire

[rtl/core/rmq_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module rmq_queue import rmq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t din,
  input  wire logic pop,
  output logic      nonempty,
  output logic      full,
  output job_t      dout
);
  job_t mem [QueueDepth];
  logic [QueueAw-1:0] wp, rp;
  logic [QueueAw:0] cnt;

  assign nonempty = (cnt != '0);
  assign full = (cnt == (QueueAw+1)'(QueueDepth));
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
    end
    if (push) mem[wp] <= din;
  end
endmodule
`default_nettype wire

[rtl/core/rmq_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module rmq_back import rmq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire job_t in_job,
  output logic      done,
  output field_t    quat_x,
  output field_t    quat_y,
  output field_t    quat_z,
  output field_t    quat_w,
  output logic      degenerate
);
  // Fully pipelined: one radicand bit pair per sqrt stage, then one quotient
  // bit per divide stage, three dividers sharing the same divisor.
  localparam int SqSt = SqW;
  localparam int DvSt = DivW;
  localparam int DenW = SqW + 2;
  localparam int RemW = DenW + 1;

  // sqrt pipe
  logic              sv  [SqSt+1];
  job_t              sj  [SqSt+1];
  logic [RadW+1:0]   srad[SqSt+1];
  logic [SqW-1:0]    sroot[SqSt+1];
  logic [SqW+2:0]    srem[SqSt+1];

  always_comb begin
    sv[0] = in_valid;
    sj[0] = in_job;
    srad[0] = {1'b0, in_job.arg, {FracBits{1'b0}}, 1'b0};
    sroot[0] = '0;
    srem[0] = '0;
  end

  for (genvar g = 0; g < SqSt; g++) begin : g_sq
    logic [SqW+2:0] r2, t;
    always_comb begin
      r2 = {srem[g][SqW:0], srad[g][RadW+1 -: 2]};
      t = {1'b0, sroot[g], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) sv[g+1] <= 1'b0;
      else sv[g+1] <= sv[g];
      sj[g+1] <= sj[g];
      srad[g+1] <= srad[g] << 2;
      if (r2 >= t) begin
        srem[g+1] <= r2 - t;
        sroot[g+1] <= {sroot[g][SqW-2:0], 1'b1};
      end else begin
        srem[g+1] <= r2;
        sroot[g+1] <= {sroot[g][SqW-2:0], 1'b0};
      end
    end
  end

  // divide pipe: q = (|n| << F + s) / (2s)
  logic              dv  [DvSt+1];
  job_t              dj  [DvSt+1];
  logic [DenW-1:0]   dden[DvSt+1];
  logic [SqW-1:0]    dhalf[DvSt+1];
  logic [DivW:0]     dnum[DvSt+1][3];
  logic [RemW-1:0]   drem[DvSt+1][3];
  logic [DivW-1:0]   dq  [DvSt+1][3];
  logic              dneg[DvSt+1][3];

  always_comb begin
    logic signed [NumW-1:0] nn [3];
    logic [NumW-1:0] mg;
    nn[0] = sj[SqSt].n0; nn[1] = sj[SqSt].n1; nn[2] = sj[SqSt].n2;
    dv[0] = sv[SqSt];
    dj[0] = sj[SqSt];
    dden[0] = {1'b0, sroot[SqSt], 1'b0};
    dhalf[0] = sroot[SqSt];
    for (int c = 0; c < 3; c++) begin
      mg = nn[c][NumW-1] ? NumW'(-nn[c]) : nn[c];
      dneg[0][c] = nn[c][NumW-1];
      dnum[0][c] = {1'b0, mg, {FracBits{1'b0}}} + (DivW+1)'(sroot[SqSt]);
      drem[0][c] = '0;
      dq[0][c] = '0;
    end
  end

  for (genvar g = 0; g < DvSt; g++) begin : g_dv
    always_ff @(posedge clk) begin
      logic [RemW-1:0] r;
      if (rst) dv[g+1] <= 1'b0;
      else dv[g+1] <= dv[g];
      dj[g+1] <= dj[g];
      dden[g+1] <= dden[g];
      dhalf[g+1] <= dhalf[g];
      for (int c = 0; c < 3; c++) begin
        r = {drem[g][c][RemW-2:0], dnum[g][c][DivW-1]};
        dneg[g+1][c] <= dneg[g][c];
        dnum[g+1][c] <= dnum[g][c] << 1;
        if (r >= RemW'(dden[g])) begin
          drem[g+1][c] <= r - RemW'(dden[g]);
          dq[g+1][c] <= {dq[g][c][DivW-2:0], 1'b1};
        end else begin
          drem[g+1][c] <= r;
          dq[g+1][c] <= {dq[g][c][DivW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [QW-1:0] v [3];
    logic signed [QW-1:0] pv;
    field_t a, b, c2, p;
    for (int c = 0; c < 3; c++) begin
      v[c] = (dq[DvSt][c] > DivW'(131072)) ? QW'(262143)
           : QW'(dq[DvSt][c]);
      if (dneg[DvSt][c]) v[c] = -v[c];
    end
    pv = QW'((dhalf[DvSt] + 1'b1) >> 1);
    a = sat18(v[0]); b = sat18(v[1]); c2 = sat18(v[2]); p = sat18(pv);
    if (rst) done <= 1'b0;
    else done <= dv[DvSt];
    degenerate <= dj[DvSt].degen;
    if (dj[DvSt].degen) begin
      quat_x <= '0; quat_y <= '0; quat_z <= '0; quat_w <= '0;
    end else begin
      unique case (dj[DvSt].pivot)
        PIV_W: begin quat_w <= p; quat_x <= a; quat_y <= b; quat_z <= c2; end
        PIV_X: begin quat_x <= p; quat_w <= a; quat_y <= b; quat_z <= c2; end
        PIV_Y: begin quat_y <= p; quat_w <= a; quat_z <= b; quat_x <= c2; end
        PIV_Z: begin quat_z <= p; quat_w <= a; quat_x <= b; quat_y <= c2; end
        default: begin quat_x <= '0; quat_y <= '0; quat_z <= '0; quat_w <= '0; end
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/core/rotation_matrix_to_quaternion.sv]
// Rotation matrix to quaternion (Shepperd's method) in signed Q2.16. A matrix
// is transferred when start is high and busy is low; busy stays low in steady
// use, so one matrix can be transferred every clock cycle. Each result appears
// once, for one cycle, with done high, after one front stage, the queue, 19
// square-root stages, 36 divider stages and one output register. The receiver
// cannot stall, so the queue between front and back only absorbs the
// classification stage and never fills in practice.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  output logic        busy,
  input  wire field_t m00, input wire field_t m01, input wire field_t m02,
  input  wire field_t m10, input wire field_t m11, input wire field_t m12,
  input  wire field_t m20, input wire field_t m21, input wire field_t m22,
  output logic        done,
  output field_t      quat_x,
  output field_t      quat_y,
  output field_t      quat_z,
  output field_t      quat_w,
  output logic        degenerate
);
  logic fv, qne, qfull;
  job_t fj, qj;

  // The back pipeline never stalls, so the queue drains every cycle.
  assign busy = qfull;

  rmq_front u_front (
    .clk, .rst, .take(start && !busy),
    .m00, .m01, .m02, .m10, .m11, .m12, .m20, .m21, .m22,
    .job_valid(fv), .job(fj)
  );

  rmq_queue u_queue (
    .clk, .rst, .push(fv), .din(fj), .pop(qne),
    .nonempty(qne), .full(qfull), .dout(qj)
  );

  rmq_back u_back (
    .clk, .rst, .in_valid(qne), .in_job(qj),
    .done, .quat_x, .quat_y, .quat_z, .quat_w, .degenerate
  );
endmodule
`default_nettype wire

[rtl/core/rmq_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module rmq_checker import rmq_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  input wire logic   start,
  input wire logic   busy,
  input wire logic   done,
  input wire field_t quat_x,
  input wire field_t quat_y,
  input wire field_t quat_z,
  input wire field_t quat_w,
  input wire logic   degenerate
);
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> quat_x == '0 && quat_y == '0 && quat_z == '0 && quat_w == '0)
    else $error("degenerate result not zero");
  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_idle_done: assert property (@(posedge clk) rst |=> !done)
    else $error("done after reset");
endmodule
bind rotation_matrix_to_quaternion rmq_checker u_chk (.*);
`default_nettype wire
